[src/lcasr_pkg.sv]
package lcasr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int READ_W      = 24;
  localparam int CMP_W       = (SAMPLE_BITS > READ_W) ? SAMPLE_BITS : READ_W;
  localparam int BIT_IDX_W   = $clog2(SAMPLE_BITS + 1);
  localparam int TIMEOUT_W   = 16;
  localparam int REPEAT_W    = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_WAIT      = 3'd1;
  localparam logic [2:0] PH_HIGH      = 3'd2;
  localparam logic [2:0] PH_LOW       = 3'd3;
  localparam logic [2:0] PH_GAIN_HIGH = 3'd4;
  localparam logic [2:0] PH_GAIN_LOW  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT   = 2'd3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [READ_W-1:0]    MIN_RESET     = 24'h000000;
  localparam logic [READ_W-1:0]    MAX_RESET     = 24'hFFFFFF;
  localparam logic [REPEAT_W-1:0]  STUCK_RESET   = 4'd10;
  localparam logic [REPEAT_W-1:0]  REPEAT_MAX    = 4'd15;

  localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [2:0]          pad;
    logic                stuck;
    logic [STATUS_W-1:0] status;
    logic [READ_W-1:0]   reading;
    logic                done_res;
    logic                sck;
  } result_t;

endpackage

[src/load_cell_adc_serial_reader_core.sv]
// A result item is registered on the edge that accepts its input item.
// Throughput: one item per cycle; s_tready stays high unless a result is held
// back by m_tready low, since the single output register parts the two sides.
// Each item is one timebase tick of the serial sequencer: a reading takes at least
// 52 ticks (start, data low, 48 bit ticks, 2 gain ticks), one more per data-high wait.
// Reset (rst, synchronous, active high) returns the sequencer to idle, clears
// the repeat tracker and the output valid, and loads register defaults.
module load_cell_adc_serial_reader_core
  import lcasr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // start_req, data_in, zero fill
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // sck, done_res, reading, status, stuck, zero fill
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [TIMEOUT_W-1:0]   timeout_ticks;
  logic [READ_W-1:0]      min_valid;
  logic [READ_W-1:0]      max_valid;
  logic [REPEAT_W-1:0]    stuck_limit;

  logic [2:0]             phase, phase_next;
  logic [BIT_IDX_W-1:0]   bit_index, bit_index_next;
  logic [SAMPLE_BITS-1:0] shift_word, shift_word_next;
  logic [TIMEOUT_W-1:0]   wait_count, wait_count_next;
  logic [SAMPLE_BITS-1:0] last_good_value, last_good_value_next;
  logic [REPEAT_W-1:0]    repeat_count, repeat_count_next;

  result_t                res, res_next;
  logic                   accept;
  logic                   start_req, data_in;
  logic [SAMPLE_BITS-1:0] conv;
  logic [CMP_W-1:0]       conv_ext;
  logic                   in_range;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign start_req = s_tdata[0];
  assign data_in   = s_tdata[1];
  assign m_tdata   = res;

  assign conv     = shift_word ^ SIGN_FLIP;
  assign conv_ext = CMP_W'(conv);
  assign in_range = (conv_ext >= CMP_W'(min_valid)) && (conv_ext <= CMP_W'(max_valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      min_valid     <= MIN_RESET;
      max_valid     <= MAX_RESET;
      stuck_limit   <= STUCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        REG_MIN_VALID:     min_valid     <= cfg_data[READ_W-1:0];
        REG_MAX_VALID:     max_valid     <= cfg_data[READ_W-1:0];
        REG_STUCK_LIMIT:   stuck_limit   <= cfg_data[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next           = phase;
    bit_index_next       = bit_index;
    shift_word_next      = shift_word;
    wait_count_next      = wait_count;
    last_good_value_next = last_good_value;
    repeat_count_next    = repeat_count;
    res_next             = '0;

    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          phase_next      = PH_WAIT;
          wait_count_next = '0;
        end
      end
      PH_WAIT: begin
        if (!data_in) begin
          phase_next      = PH_HIGH;
          bit_index_next  = '0;
          shift_word_next = '0;
        end else if (wait_count == timeout_ticks) begin
          res_next.done_res = 1'b1;
          res_next.status   = ST_TIMEOUT;
          phase_next        = PH_IDLE;
        end else begin
          wait_count_next = wait_count + 1'b1;
        end
      end
      PH_HIGH: begin
        res_next.sck    = 1'b1;
        shift_word_next = {shift_word[SAMPLE_BITS-2:0], 1'b0};
        phase_next      = PH_LOW;
      end
      PH_LOW: begin
        shift_word_next = {shift_word[SAMPLE_BITS-1:1], shift_word[0] | data_in};
        bit_index_next  = bit_index + 1'b1;
        phase_next      = (bit_index_next >= BIT_IDX_W'(SAMPLE_BITS)) ? PH_GAIN_HIGH : PH_HIGH;
      end
      PH_GAIN_HIGH: begin
        res_next.sck = 1'b1;
        phase_next   = PH_GAIN_LOW;
      end
      PH_GAIN_LOW: begin
        res_next.done_res = 1'b1;
        phase_next        = PH_IDLE;
        if (!in_range) begin
          res_next.status = ST_RANGE;
        end else begin
          if ((conv == last_good_value) && (conv != '0)) begin
            if (repeat_count < REPEAT_MAX) begin
              repeat_count_next = repeat_count + 1'b1;
            end
            res_next.stuck = (repeat_count_next > stuck_limit);
          end else begin
            repeat_count_next    = '0;
            last_good_value_next = conv;
          end
          res_next.reading = conv_ext[READ_W-1:0];
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_index       <= '0;
      shift_word      <= '0;
      wait_count      <= '0;
      last_good_value <= '0;
      repeat_count    <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        bit_index       <= bit_index_next;
        shift_word      <= shift_word_next;
        wait_count      <= wait_count_next;
        last_good_value <= last_good_value_next;
        repeat_count    <= repeat_count_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  a_fail_clears_reading: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.status != ST_OK) |-> (res.reading == '0 && !res.stuck))
    else $error("failed attempt carries a reading or stuck flag");

  a_high_tick_drives_sck: assert property (@(posedge clk) disable iff (rst)
    (accept && (phase == PH_HIGH || phase == PH_GAIN_HIGH)) |=> (m_tvalid && res.sck))
    else $error("clock high tick without sck");

  a_wait_low_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_WAIT && !data_in) |=> (phase == PH_HIGH && bit_index == '0))
    else $error("data low in wait did not start clocking");

  a_bit_index_bound: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BIT_IDX_W'(SAMPLE_BITS))
    else $error("bit index beyond sample width");

  a_done_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (accept && phase != PH_WAIT && phase != PH_GAIN_LOW) |=> !res.done_res)
    else $error("done outside wait or final tick");

endmodule

[tb/sv/lcasr_tick_checker.sv]
`timescale 1ns / 100ps
module lcasr_tick_checker
  import lcasr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // start_req, data_in, zero fill
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // sck, done_res, reading, status, stuck, zero fill
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     ticks_checked,
  output int                     good_reads,
  output int                     timeouts,
  output int                     range_errs,
  output int                     stuck_flags
);

  logic [TIMEOUT_W-1:0]   timeout_lim;
  logic [READ_W-1:0]      min_ok;
  logic [READ_W-1:0]      max_ok;
  logic [REPEAT_W-1:0]    stuck_lim;

  logic [2:0]             seq_phase;
  logic [BIT_IDX_W-1:0]   bits_taken;
  logic [SAMPLE_BITS-1:0] shift_word;
  logic [TIMEOUT_W-1:0]   high_ticks;
  logic [SAMPLE_BITS-1:0] last_good;
  logic [REPEAT_W-1:0]    repeats;

  result_t expected_ticks[$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("tick %0d: %s expected %0h got %0h", ticks_checked, what, want, got);
    mismatches++;
  endtask

  // one timebase tick of the sequencer
  function automatic result_t predict_tick(input logic start, input logic din);
    result_t r;
    logic [SAMPLE_BITS-1:0] v;
    r = '0;
    case (seq_phase)
      PH_IDLE: begin
        if (start) begin
          seq_phase  = PH_WAIT;
          high_ticks = '0;
        end
      end
      PH_WAIT: begin
        if (!din) begin
          seq_phase  = PH_HIGH;
          bits_taken = '0;
          shift_word = '0;
        end else if (high_ticks == timeout_lim) begin
          r.done_res = 1'b1;
          r.status   = ST_TIMEOUT;
          seq_phase  = PH_IDLE;
        end else begin
          high_ticks = high_ticks + 1'b1;
        end
      end
      PH_HIGH: begin
        r.sck      = 1'b1;
        shift_word = shift_word << 1;
        seq_phase  = PH_LOW;
      end
      PH_LOW: begin
        shift_word[0] = din;
        bits_taken    = bits_taken + 1'b1;
        seq_phase     = (bits_taken >= SAMPLE_BITS) ? PH_GAIN_HIGH : PH_HIGH;
      end
      PH_GAIN_HIGH: begin
        r.sck     = 1'b1;
        seq_phase = PH_GAIN_LOW;
      end
      default: begin
        // gain-select low tick: convert and finish
        v          = shift_word ^ SIGN_FLIP;
        r.done_res = 1'b1;
        seq_phase  = PH_IDLE;
        if (CMP_W'(v) < CMP_W'(min_ok) || CMP_W'(v) > CMP_W'(max_ok)) begin
          r.status = ST_RANGE;
        end else begin
          if (v == last_good && v != '0) begin
            if (repeats < REPEAT_MAX) repeats = repeats + 1'b1;
            r.stuck = (repeats > stuck_lim);
          end else begin
            repeats   = '0;
            last_good = v;
          end
          r.reading = READ_W'(v);
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      timeout_lim = TIMEOUT_RESET;
      min_ok      = MIN_RESET;
      max_ok      = MAX_RESET;
      stuck_lim   = STUCK_RESET;
      seq_phase   = PH_IDLE;
      bits_taken  = '0;
      shift_word  = '0;
      high_ticks  = '0;
      last_good   = '0;
      repeats     = '0;
      expected_ticks.delete();
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TIMEOUT_TICKS: timeout_lim = cfg_data[TIMEOUT_W-1:0];
          REG_MIN_VALID:     min_ok      = cfg_data[READ_W-1:0];
          REG_MAX_VALID:     max_ok      = cfg_data[READ_W-1:0];
          REG_STUCK_LIMIT:   stuck_lim   = cfg_data[REPEAT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (expected_ticks.size() == 0) begin
          report_mismatch("result with nothing pending", '0, m_tdata);
        end else begin
          want = expected_ticks.pop_front();
          if (got.sck !== want.sck) report_mismatch("sck", 32'(want.sck), 32'(got.sck));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 32'(want.done_res), 32'(got.done_res));
          if (got.reading !== want.reading)
            report_mismatch("reading", 32'(want.reading), 32'(got.reading));
          if (got.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(got.status));
          if (got.stuck !== want.stuck)
            report_mismatch("stuck", 32'(want.stuck), 32'(got.stuck));
          if (want.done_res) begin
            case (want.status)
              ST_OK: begin
                good_reads++;
                if (want.stuck) stuck_flags++;
              end
              ST_TIMEOUT: timeouts++;
              default:    range_errs++;
            endcase
          end
        end
        ticks_checked++;
      end
      if (s_tvalid && s_tready) begin
        expected_ticks.push_back(predict_tick(s_tdata[0], s_tdata[1]));
      end
      outstanding = expected_ticks.size();
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
module tb;
  import lcasr_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int CALM_AFTER  = 1700;
  localparam int HOLD_AFTER  = 800;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // start_req, data_in, zero fill
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // sck, done_res, reading, status, stuck, zero fill
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int mismatches;
  int outstanding;
  int ticks_checked;
  int good_reads;
  int timeouts;
  int range_errs;
  int stuck_flags;

  int items_sent = 0;
  int cycles     = 0;
  int settings   = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;

  logic [TIMEOUT_W-1:0] cur_timeout = TIMEOUT_RESET;
  logic [READ_W-1:0]    cur_min     = MIN_RESET;
  logic [READ_W-1:0]    cur_max     = MAX_RESET;
  logic [READ_W-1:0]    last_target = '0;

  always #2 clk = ~clk;

  load_cell_adc_serial_reader_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcasr_tick_checker u_tick_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .ticks_checked (ticks_checked),
    .good_reads    (good_reads),
    .timeouts      (timeouts),
    .range_errs    (range_errs),
    .stuck_flags   (stuck_flags)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results pending", cycles, outstanding);
      $display("load_cell_adc_serial_reader_core regression: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    wait (!rst);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic drive_tick(input logic start, input logic din);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({din, start});
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  // stop offering and let every pending result drain
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [3:0] sel, input logic [TIMEOUT_W-1:0] t,
                              input logic [READ_W-1:0] lo, input logic [READ_W-1:0] hi,
                              input logic [REPEAT_W-1:0] sl);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx[0] = REG_TIMEOUT_TICKS;
    idx[1] = REG_MIN_VALID;
    idx[2] = REG_MAX_VALID;
    idx[3] = REG_STUCK_LIMIT;
    // unused upper bits carry noise
    val[0] = {8'($urandom()), t};
    val[1] = lo;
    val[2] = hi;
    val[3] = {20'($urandom()), sl};
    for (int r = 0; r < 4; r++) begin
      if (sel[r]) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx[r];
        cfg_data  <= val[r];
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
    if (sel[0]) cur_timeout = t;
    if (sel[1]) cur_min = lo;
    if (sel[2]) cur_max = hi;
    settings++;
  endtask

  // start, data-high wait ticks, data low, 24 clocked bits, gain pulse
  task automatic send_reading(input int wait_ticks, input logic [READ_W-1:0] v);
    logic [SAMPLE_BITS-1:0] word;
    word = SAMPLE_BITS'(v) ^ SIGN_FLIP;
    last_target = v;
    drive_tick(1'b1, coin());
    repeat (wait_ticks) drive_tick(coin(), 1'b1);
    drive_tick(coin(), 1'b0);
    for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
      if (b == 12 && items_sent > HOLD_AFTER) hold_req = 1'b1;
      drive_tick(coin(), coin());
      drive_tick(coin(), word[b]);
    end
    drive_tick(coin(), coin());
    drive_tick(coin(), coin());
  endtask

  task automatic send_timeout();
    drive_tick(1'b1, coin());
    repeat (int'(cur_timeout) + 1) drive_tick(coin(), 1'b1);
  endtask

  function automatic int pick_wait();
    int cap;
    cap = (cur_timeout < 8) ? int'(cur_timeout) : 8;
    if (cur_timeout <= 40 && $urandom_range(0, 4) == 0) return int'(cur_timeout);
    return $urandom_range(0, cap);
  endfunction

  function automatic logic [READ_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return last_target;
      4:          return cur_min;
      5:          return cur_max;
      6:          return cur_min - 1'b1;
      7:          return cur_max + 1'b1;
      8:          return coin() ? '0 : '1;
      default:    return READ_W'($urandom());
    endcase
  endfunction

  task automatic random_phase(input bit all_regs);
    logic [3:0]           sel;
    logic [TIMEOUT_W-1:0] t;
    logic [READ_W-1:0]    lo;
    logic [READ_W-1:0]    hi;
    logic [REPEAT_W-1:0]  sl;
    sel = all_regs ? 4'hF : 4'($urandom_range(1, 15));
    case ($urandom_range(0, 5))
      0:       t = '0;
      1:       t = '1;
      2:       t = TIMEOUT_W'($urandom());
      default: t = TIMEOUT_W'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 3))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = READ_W'($urandom());
        hi = lo + READ_W'($urandom_range(0, 24'h3FFFFF));
      end
      2: begin
        lo = READ_W'($urandom());
        hi = READ_W'($urandom());
      end
      default: begin
        lo = '0;
        hi = READ_W'($urandom());
      end
    endcase
    sl = ($urandom_range(0, 2) == 0) ? REPEAT_W'($urandom_range(0, 14))
                                     : REPEAT_W'($urandom_range(0, 3));
    write_config(sel, t, lo, hi, sl);
    repeat ($urandom_range(3, 8)) begin
      if (items_sent < ITEM_TARGET) begin
        case ($urandom_range(0, 9))
          0: begin
            if (cur_timeout <= 40) send_timeout();
            else send_reading(pick_wait(), pick_target());
          end
          1: repeat ($urandom_range(1, 6)) drive_tick(1'b0, coin());
          default: send_reading(pick_wait(), pick_target());
        endcase
      end
    end
  endtask

  initial begin
    bit first;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle ticks, then readings at reset defaults: zero and full scale
    drive_tick(1'b0, 1'b0);
    drive_tick(1'b0, 1'b1);
    send_reading(2, 24'h000000);
    send_reading(0, 24'hFFFFFF);
    settle();

    // zero timeout, stuck on first repeat, zero never counts as stuck
    write_config(4'hF, 16'd0, 24'h000000, 24'hFFFFFF, 4'd0);
    send_timeout();
    send_reading(0, 24'h123456);
    send_reading(0, 24'h123456);
    send_reading(0, 24'h000000);
    send_reading(0, 24'h000000);
    settle();

    // window one step in from each end, widest timeout, highest stuck limit that can still flag
    write_config(4'hF, 16'hFFFF, 24'h000001, 24'hFFFFFE, 4'd14);
    send_reading(3, 24'h000000);
    send_reading(1, 24'hFFFFFF);
    send_reading(0, 24'h000001);
    send_reading(2, 24'hFFFFFE);
    settle();

    // wait exactly the timeout, then one tick more
    write_config(4'b0001, 16'd5, '0, '0, '0);
    send_reading(5, 24'h800000);
    send_timeout();

    first = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      settle();
      random_phase(first);
      first = 1'b0;
    end
    settle();

    $display("%0d ticks checked over %0d register settings: %0d readings ok (%0d stuck)",
             ticks_checked, settings, good_reads, stuck_flags);
    $display("%0d timeouts, %0d out of range, %0d mismatches",
             timeouts, range_errs, mismatches);
    if (mismatches == 0) begin
      $display("load_cell_adc_serial_reader_core regression: pass");
    end else begin
      $display("load_cell_adc_serial_reader_core regression: fail");
    end
    $finish;
  end

endmodule
